// ===== src/ray_disk_intersect_assert.svh =====
// Assertion macros for the ray/disk intersection block.
`ifndef RAY_DISK_INTERSECT_ASSERT_SVH
`define RAY_DISK_INTERSECT_ASSERT_SVH
`ifndef SYNTHESIS
`define RDI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rdi: same-cycle check failed");
`define RDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rdi: next-cycle check failed");
`else
`define RDI_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RDI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/rdi_pkg.sv =====
// Shared constants, types and the arctangent table for the ray/disk block.
package rdi_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int DIV1_W     = 65;   // |dir * num| and |num << frac|
    localparam int DIV2_W     = 63;   // R * |p| and (R - r) << 16
    localparam int DEN_W      = 32;
    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = SQRT_IN_W / 2;
    localparam int CORDIC_W   = 35;

    localparam logic [31:0] TWO_PI_Q29    = 32'd3373259426;
    localparam logic [30:0] LEN_UNBOUNDED = 31'h7FFF_FFFF;
    localparam logic [31:0] ANG_HALF_TURN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CFG_RADIUS = 2'd0,
        CFG_HEIGHT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic [30:0]        len;
        logic               neg_t;
        logic               neg_x;
        logic               neg_y;
        logic               dz_zero;
    } side1_t;

    typedef struct packed {
        logic               hit;
        logic [30:0]        t;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [31:0]        absx;
        logic [31:0]        absy;
        logic signed [31:0] dux;
        logic signed [31:0] duy;
        logic               zero;
    } side2_t;

    typedef struct packed {
        logic               hit;
        logic [30:0]        t;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] dux;
        logic signed [31:0] duy;
        logic [15:0]        u;
        logic               r_zero;
        logic               px_pos;
        logic               py_pos;
    } side3_t;

    // atan(2^-i) in turns, 2^32 = full circle
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] a;
        unique case (idx)
            5'd0:  a = 32'h2000_0000;
            5'd1:  a = 32'h12E4_051E;
            5'd2:  a = 32'h09FB_385B;
            5'd3:  a = 32'h0511_11D4;
            5'd4:  a = 32'h028B_0D43;
            5'd5:  a = 32'h0145_D7E1;
            5'd6:  a = 32'h00A2_F61E;
            5'd7:  a = 32'h0051_7C55;
            5'd8:  a = 32'h0028_BE53;
            5'd9:  a = 32'h0014_5F2F;
            5'd10: a = 32'h000A_2F98;
            5'd11: a = 32'h0005_17CC;
            5'd12: a = 32'h0002_8BE6;
            5'd13: a = 32'h0001_45F3;
            5'd14: a = 32'h0000_A2FA;
            5'd15: a = 32'h0000_517D;
            5'd16: a = 32'h0000_28BE;
            5'd17: a = 32'h0000_145F;
            5'd18: a = 32'h0000_0A30;
            5'd19: a = 32'h0000_0518;
            5'd20: a = 32'h0000_028C;
            5'd21: a = 32'h0000_0146;
            5'd22: a = 32'h0000_00A3;
            5'd23: a = 32'h0000_0051;
            5'd24: a = 32'h0000_0029;
            5'd25: a = 32'h0000_0014;
            5'd26: a = 32'h0000_000A;
            5'd27: a = 32'h0000_0005;
            5'd28: a = 32'h0000_0003;
            5'd29: a = 32'h0000_0001;
            5'd30: a = 32'h0000_0001;
            5'd31: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

endpackage

// ===== src/rdi_delay.sv =====
// Enabled delay line for sideband data with a reset valid chain.
module rdi_delay import rdi_pkg::*; #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         vld_in,
    input  logic [W-1:0] din,
    output logic         vld_out,
    output logic [W-1:0] dout
);

    generate
        if (DEPTH == 0) begin : g_pass
            assign vld_out = vld_in;
            assign dout    = din;
        end else begin : g_line
            logic [W-1:0] dat_reg [DEPTH];
            logic [DEPTH-1:0] vld_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg <= '0;
                end else if (en) begin
                    vld_reg <= {vld_reg[DEPTH-2 >= 0 ? DEPTH-2 : 0:0], vld_in};
                end
            end

            for (genvar i = 0; i < DEPTH; i++) begin : g_tap
                always_ff @(posedge aclk) begin
                    if (en) begin
                        dat_reg[i] <= (i == 0) ? din : dat_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end

            assign vld_out = vld_reg[DEPTH-1];
            assign dout    = dat_reg[DEPTH-1];
        end
    endgenerate

endmodule

// ===== src/rdi_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
module rdi_div import rdi_pkg::*; #(
    parameter int NUM_W = DIV1_W,
    parameter int DEN_W_P = DEN_W
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W_P-1:0] den,
    output logic [NUM_W-1:0]   quo
);

    // numerator bits shift out the top while quotient bits shift in below
    logic [NUM_W-1:0]   nq_reg  [NUM_W];
    logic [DEN_W_P-1:0] rem_reg [NUM_W];
    logic [DEN_W_P-1:0] den_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [NUM_W-1:0]   nq_in;
        logic [DEN_W_P-1:0] rem_in;
        logic [DEN_W_P-1:0] den_in;
        logic [DEN_W_P:0]   trial;
        logic               ge;
        logic [DEN_W_P:0]   diff;

        if (i == 0) begin : g_first
            assign nq_in  = num;
            assign rem_in = '0;
            assign den_in = den;
        end else begin : g_next
            assign nq_in  = nq_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial = {rem_in, nq_in[NUM_W-1]};
        assign ge    = trial >= {1'b0, den_in};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[i]  <= {nq_in[NUM_W-2:0], ge};
                rem_reg[i] <= ge ? diff[DEN_W_P-1:0] : trial[DEN_W_P-1:0];
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = nq_reg[NUM_W-1];

endmodule

// ===== src/rdi_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rdi_sqrt import rdi_pkg::*; #(
    parameter int IN_W = SQRT_IN_W
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [IN_W-1:0]   rad,
    output logic [IN_W/2-1:0] root
);

    localparam int OUT_W = IN_W / 2;

    logic [IN_W:0]    rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];

    for (genvar i = 0; i < OUT_W; i++) begin : g_stage
        localparam int B = OUT_W - 1 - i;
        logic [IN_W:0]    rem_in;
        logic [OUT_W-1:0] root_in;
        logic [IN_W:0]    cand;
        logic             take;

        if (i == 0) begin : g_first
            assign rem_in  = {1'b0, rad};
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        // (root + 2^B)^2 - root^2
        assign cand = ((IN_W+1)'(root_in) << (B + 1)) | ((IN_W+1)'(1) << (2 * B));
        assign take = rem_in >= cand;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? rem_in - cand : rem_in;
                root_reg[i] <= take ? (root_in | (OUT_W'(1) << B)) : root_in;
            end
        end
    end

    assign root = root_reg[OUT_W-1];

endmodule

// ===== src/rdi_cordic.sv =====
// Pipelined CORDIC vectoring stages, angle accumulated in turns.
module rdi_cordic import rdi_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    input  logic [31:0]                ang_in,
    output logic [31:0]                ang_out
);

    logic signed [CORDIC_W-1:0] x_reg   [STEPS];
    logic signed [CORDIC_W-1:0] y_reg   [STEPS];
    logic [31:0]                ang_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic [31:0]                as;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        logic [31:0]                step_ang;

        if (i == 0) begin : g_first
            assign xs = x_in;
            assign ys = y_in;
            assign as = ang_in;
        end else begin : g_next
            assign xs = x_reg[i-1];
            assign ys = y_reg[i-1];
            assign as = ang_reg[i-1];
        end

        assign dx       = ys >>> (i % 32);
        assign dy       = xs >>> (i % 32);
        assign step_ang = atan_turn(5'(i % 32));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!ys[CORDIC_W-1]) begin
                    x_reg[i]   <= xs + dx;
                    y_reg[i]   <= ys - dy;
                    ang_reg[i] <= as + step_ang;
                end else begin
                    x_reg[i]   <= xs - dx;
                    y_reg[i]   <= ys + dy;
                    ang_reg[i] <= as - step_ang;
                end
            end
        end
    end

    assign ang_out = ang_reg[STEPS-1];

endmodule

// ===== src/ray_disk_intersect.sv =====
// Throughput: one ray per cycle; all stages advance together, held while output stalls.
// Pipeline depth is set mostly by the two bit-serial divider pipelines and the 32-stage square root.
// Reset: aresetn synchronous active low; clears valid bits and loads radius 1.0, height 0.
// Datapath registers carry no reset; their content is ignored until a valid bit reaches them.
// Top level of the ray/disk intersection pipeline.
`include "ray_disk_intersect_assert.svh"
module ray_disk_intersect import rdi_pkg::*; #(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input rays
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] origin_x, [63:32] origin_y, [95:64] origin_z, [127:96] dir_x,
    // [159:128] dir_y, [191:160] dir_z, [222:192] max_length, [223] zero pad
    input  logic [223:0] s_tdata,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    // [30:0] hit_distance, [62:31] point_x, [94:63] point_y, [110:95] coord_u,
    // [127:111] coord_v, [159:128] dpdu_x, [191:160] dpdu_y, [223:192] dpdv_x,
    // [255:224] dpdv_y
    output logic [255:0] m_tdata,
    // [0] hit
    output logic [0:0]   m_tuser,
    // register writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int TN_W      = 33 + FRAC_BITS;   // width of num << FRAC_BITS
    localparam int ANG_DELAY = SQRT_OUT_W - CORDIC_STEPS;

    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        logic signed [31:0] s;
        if (v[65:31] == '0 || v[65:31] == '1) s = v[31:0];
        else if (v[65]) s = 32'sh8000_0000;
        else s = 32'sh7FFF_FFFF;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [30:0]        disk_radius_reg;
    logic signed [31:0] disk_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_radius_reg <= 31'd65536;
            disk_height_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RADIUS: disk_radius_reg <= cfg_data[30:0];
                CFG_HEIGHT: disk_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the output register is free or drained.
    logic adv;
    logic m_valid_reg;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // S1: capture ray, plane offset num = height - oz
    // ------------------------------------------------------------------
    logic               s1_vld_reg;
    logic signed [32:0] s1_num_reg;
    logic signed [31:0] s1_ox_reg, s1_oy_reg, s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic [30:0]        s1_len_reg;
    logic signed [31:0] in_oz;

    assign in_oz = s_tdata[95:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) s1_vld_reg <= 1'b0;
        else if (adv) s1_vld_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_num_reg <= {disk_height_reg[31], disk_height_reg} - {in_oz[31], in_oz};
            s1_ox_reg  <= s_tdata[31:0];
            s1_oy_reg  <= s_tdata[63:32];
            s1_dx_reg  <= s_tdata[127:96];
            s1_dy_reg  <= s_tdata[159:128];
            s1_dz_reg  <= s_tdata[191:160];
            s1_len_reg <= s_tdata[222:192];
        end
    end

    // ------------------------------------------------------------------
    // S2: numerator products
    // ------------------------------------------------------------------
    logic               s2_vld_reg;
    logic signed [64:0] s2_prodx_reg, s2_prody_reg;
    logic signed [TN_W-1:0] s2_tnum_reg;
    logic signed [31:0] s2_ox_reg, s2_oy_reg, s2_dz_reg;
    logic [30:0]        s2_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s2_vld_reg <= 1'b0;
        else if (adv) s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_prodx_reg <= s1_dx_reg * s1_num_reg;
            s2_prody_reg <= s1_dy_reg * s1_num_reg;
            s2_tnum_reg  <= {s1_num_reg, {FRAC_BITS{1'b0}}};
            s2_ox_reg    <= s1_ox_reg;
            s2_oy_reg    <= s1_oy_reg;
            s2_dz_reg    <= s1_dz_reg;
            s2_len_reg   <= s1_len_reg;
        end
    end

    // ------------------------------------------------------------------
    // S3: magnitudes and quotient signs for the first dividers
    // ------------------------------------------------------------------
    logic              s3_vld_reg;
    logic [DIV1_W-1:0] s3_magt_reg, s3_magx_reg, s3_magy_reg;
    logic [31:0]       s3_magdz_reg;
    side1_t            s3_side_reg;
    logic [TN_W-1:0]   abs_tnum;

    assign abs_tnum = s2_tnum_reg[TN_W-1] ? TN_W'(-s2_tnum_reg) : s2_tnum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s3_vld_reg <= 1'b0;
        else if (adv) s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_magt_reg  <= DIV1_W'(abs_tnum);
            s3_magx_reg  <= s2_prodx_reg[64] ? DIV1_W'(-s2_prodx_reg) : s2_prodx_reg;
            s3_magy_reg  <= s2_prody_reg[64] ? DIV1_W'(-s2_prody_reg) : s2_prody_reg;
            s3_magdz_reg <= s2_dz_reg[31] ? 32'(-s2_dz_reg) : s2_dz_reg;
            s3_side_reg.ox      <= s2_ox_reg;
            s3_side_reg.oy      <= s2_oy_reg;
            s3_side_reg.len     <= s2_len_reg;
            s3_side_reg.neg_t   <= s2_tnum_reg[TN_W-1] ^ s2_dz_reg[31];
            s3_side_reg.neg_x   <= s2_prodx_reg[64] ^ s2_dz_reg[31];
            s3_side_reg.neg_y   <= s2_prody_reg[64] ^ s2_dz_reg[31];
            s3_side_reg.dz_zero <= s2_dz_reg == '0;
        end
    end

    // t, offset x and offset y share one divider latency
    logic [DIV1_W-1:0] q_t, q_x, q_y;
    logic              d1_vld;
    side1_t            d1_side;

    rdi_div #(.NUM_W(DIV1_W), .DEN_W_P(DEN_W)) u_div_t (
        .aclk(aclk), .en(adv), .num(s3_magt_reg), .den(s3_magdz_reg), .quo(q_t));
    rdi_div #(.NUM_W(DIV1_W), .DEN_W_P(DEN_W)) u_div_x (
        .aclk(aclk), .en(adv), .num(s3_magx_reg), .den(s3_magdz_reg), .quo(q_x));
    rdi_div #(.NUM_W(DIV1_W), .DEN_W_P(DEN_W)) u_div_y (
        .aclk(aclk), .en(adv), .num(s3_magy_reg), .den(s3_magdz_reg), .quo(q_y));

    rdi_delay #(.W($bits(side1_t)), .DEPTH(DIV1_W)) u_dly1 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_in(s3_vld_reg), .din(s3_side_reg),
        .vld_out(d1_vld), .dout(d1_side));

    // ------------------------------------------------------------------
    // S4: restore quotient signs (truncating division)
    // ------------------------------------------------------------------
    logic               s4_vld_reg;
    logic signed [65:0] s4_t_reg, s4_offx_reg, s4_offy_reg;
    side1_t             s4_side_reg;
    logic [65:0]        qt_w, qx_w, qy_w;

    assign qt_w = {1'b0, q_t};
    assign qx_w = {1'b0, q_x};
    assign qy_w = {1'b0, q_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) s4_vld_reg <= 1'b0;
        else if (adv) s4_vld_reg <= d1_vld;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_t_reg    <= d1_side.neg_t ? -qt_w : qt_w;
            s4_offx_reg <= d1_side.neg_x ? -qx_w : qx_w;
            s4_offy_reg <= d1_side.neg_y ? -qy_w : qy_w;
            s4_side_reg <= d1_side;
        end
    end

    // ------------------------------------------------------------------
    // S5: hit point, range checks on t and the point
    // ------------------------------------------------------------------
    logic               s5_vld_reg, s5_hit_reg;
    logic [30:0]        s5_t_reg;
    logic signed [31:0] s5_px_reg, s5_py_reg;
    logic signed [66:0] px_w, py_w;
    logic               t_pos, t_short, fit_x, fit_y;

    assign px_w    = {{35{s4_side_reg.ox[31]}}, s4_side_reg.ox} + {s4_offx_reg[65], s4_offx_reg};
    assign py_w    = {{35{s4_side_reg.oy[31]}}, s4_side_reg.oy} + {s4_offy_reg[65], s4_offy_reg};
    assign fit_x   = px_w[66:31] == '0 || px_w[66:31] == '1;
    assign fit_y   = py_w[66:31] == '0 || py_w[66:31] == '1;
    assign t_pos   = !s4_t_reg[65] && s4_t_reg != '0;
    assign t_short = s4_side_reg.len == LEN_UNBOUNDED ||
                     s4_t_reg[64:0] < {34'b0, s4_side_reg.len};

    always_ff @(posedge aclk) begin
        if (!aresetn) s5_vld_reg <= 1'b0;
        else if (adv) s5_vld_reg <= s4_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_hit_reg <= !s4_side_reg.dz_zero && t_pos && t_short && fit_x && fit_y;
            s5_t_reg   <= (s4_t_reg[64:31] != '0) ? LEN_UNBOUNDED : s4_t_reg[30:0];
            s5_px_reg  <= px_w[31:0];
            s5_py_reg  <= py_w[31:0];
        end
    end

    // ------------------------------------------------------------------
    // S6: squares, R^2 and the 2pi products
    // ------------------------------------------------------------------
    logic               s6_vld_reg, s6_hit_reg;
    logic [30:0]        s6_t_reg;
    logic signed [31:0] s6_px_reg, s6_py_reg;
    logic signed [63:0] s6_sqx_reg, s6_sqy_reg;
    logic signed [64:0] s6_pdx_reg, s6_pdy_reg;
    logic [61:0]        s6_rr_reg;
    logic signed [32:0] two_pi_s;

    assign two_pi_s = {1'b0, TWO_PI_Q29};

    always_ff @(posedge aclk) begin
        if (!aresetn) s6_vld_reg <= 1'b0;
        else if (adv) s6_vld_reg <= s5_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_hit_reg <= s5_hit_reg;
            s6_t_reg   <= s5_t_reg;
            s6_px_reg  <= s5_px_reg;
            s6_py_reg  <= s5_py_reg;
            s6_sqx_reg <= s5_px_reg * s5_px_reg;
            s6_sqy_reg <= s5_py_reg * s5_py_reg;
            s6_pdx_reg <= s5_px_reg * two_pi_s;
            s6_pdy_reg <= s5_py_reg * two_pi_s;
            s6_rr_reg  <= disk_radius_reg * disk_radius_reg;
        end
    end

    // ------------------------------------------------------------------
    // S7: r^2, disk test, dp/du, CORDIC half-plane fold
    // ------------------------------------------------------------------
    logic                       s7_vld_reg;
    logic [63:0]                s7_d2_reg;
    side2_t                     s7_side_reg;
    logic signed [CORDIC_W-1:0] s7_x0_reg, s7_y0_reg;
    logic [31:0]                s7_ang0_reg;
    logic [63:0]                d2;
    logic signed [65:0]         du_x_w, du_y_w;
    logic signed [CORDIC_W-1:0] px_e, py_e;

    // floor shift of the signed 2pi products
    assign d2     = 64'(s6_sqx_reg) + 64'(s6_sqy_reg);
    assign du_x_w = $signed(-{s6_pdy_reg[64], s6_pdy_reg}) >>> 29;
    assign du_y_w = $signed({s6_pdx_reg[64], s6_pdx_reg}) >>> 29;
    assign px_e   = CORDIC_W'(s6_px_reg);
    assign py_e   = CORDIC_W'(s6_py_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) s7_vld_reg <= 1'b0;
        else if (adv) s7_vld_reg <= s6_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s7_d2_reg        <= d2;
            s7_side_reg.hit  <= s6_hit_reg && d2 <= {2'b0, s6_rr_reg};
            s7_side_reg.t    <= s6_t_reg;
            s7_side_reg.px   <= s6_px_reg;
            s7_side_reg.py   <= s6_py_reg;
            s7_side_reg.absx <= s6_px_reg[31] ? 32'(-s6_px_reg) : s6_px_reg;
            s7_side_reg.absy <= s6_py_reg[31] ? 32'(-s6_py_reg) : s6_py_reg;
            s7_side_reg.dux  <= sat66(du_x_w);
            s7_side_reg.duy  <= sat66(du_y_w);
            s7_side_reg.zero <= s6_px_reg == '0 && s6_py_reg == '0;
            // left half plane: rotate by half a turn first
            s7_x0_reg   <= s6_px_reg[31] ? -px_e : px_e;
            s7_y0_reg   <= s6_px_reg[31] ? -py_e : py_e;
            s7_ang0_reg <= s6_px_reg[31] ? ANG_HALF_TURN : '0;
        end
    end

    // square root and angle run side by side
    logic [SQRT_OUT_W-1:0] root;
    logic [31:0]           ang_raw, ang_al;
    logic                  d2_vld, ang_vld;
    side2_t                d2_side;

    rdi_sqrt #(.IN_W(SQRT_IN_W)) u_sqrt (
        .aclk(aclk), .en(adv), .rad(s7_d2_reg), .root(root));

    rdi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .en(adv), .x_in(s7_x0_reg), .y_in(s7_y0_reg),
        .ang_in(s7_ang0_reg), .ang_out(ang_raw));

    rdi_delay #(.W(32), .DEPTH(ANG_DELAY)) u_dly_ang (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_in(1'b0), .din(ang_raw),
        .vld_out(ang_vld), .dout(ang_al));

    rdi_delay #(.W($bits(side2_t)), .DEPTH(SQRT_OUT_W)) u_dly2 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_in(s7_vld_reg), .din(s7_side_reg),
        .vld_out(d2_vld), .dout(d2_side));

    // ------------------------------------------------------------------
    // S8: u rounding, numerators for v and dp/dv
    // ------------------------------------------------------------------
    logic              s8_vld_reg;
    logic [DIV2_W-1:0] s8_vnum_reg, s8_dvnx_reg, s8_dvny_reg;
    logic [31:0]       s8_r_reg;
    side3_t            s8_side_reg;
    logic [16:0]       u_round;
    logic [30:0]       r_gap;

    assign u_round = 17'((18'(ang_al[31:15]) + 18'd1) >> 1);
    assign r_gap   = disk_radius_reg - root[30:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) s8_vld_reg <= 1'b0;
        else if (adv) s8_vld_reg <= d2_vld;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_vnum_reg <= DIV2_W'({r_gap, 16'b0});
            s8_dvnx_reg <= disk_radius_reg * d2_side.absx;
            s8_dvny_reg <= disk_radius_reg * d2_side.absy;
            s8_r_reg    <= root;
            s8_side_reg.hit    <= d2_side.hit;
            s8_side_reg.t      <= d2_side.t;
            s8_side_reg.px     <= d2_side.px;
            s8_side_reg.py     <= d2_side.py;
            s8_side_reg.dux    <= d2_side.dux;
            s8_side_reg.duy    <= d2_side.duy;
            s8_side_reg.u      <= (d2_side.zero || ang_vld) ? 16'd0 : u_round[15:0];
            s8_side_reg.r_zero <= root == '0;
            s8_side_reg.px_pos <= !d2_side.px[31] && d2_side.px != '0;
            s8_side_reg.py_pos <= !d2_side.py[31] && d2_side.py != '0;
        end
    end

    logic [DIV2_W-1:0] q_v, q_dx, q_dy;
    logic              d3_vld;
    side3_t            d3_side;

    rdi_div #(.NUM_W(DIV2_W), .DEN_W_P(DEN_W)) u_div_v (
        .aclk(aclk), .en(adv), .num(s8_vnum_reg), .den({1'b0, disk_radius_reg}), .quo(q_v));
    rdi_div #(.NUM_W(DIV2_W), .DEN_W_P(DEN_W)) u_div_dx (
        .aclk(aclk), .en(adv), .num(s8_dvnx_reg), .den(s8_r_reg), .quo(q_dx));
    rdi_div #(.NUM_W(DIV2_W), .DEN_W_P(DEN_W)) u_div_dy (
        .aclk(aclk), .en(adv), .num(s8_dvny_reg), .den(s8_r_reg), .quo(q_dy));

    rdi_delay #(.W($bits(side3_t)), .DEPTH(DIV2_W)) u_dly3 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .vld_in(s8_vld_reg), .din(s8_side_reg),
        .vld_out(d3_vld), .dout(d3_side));

    // ------------------------------------------------------------------
    // Output register: signs, saturation, miss zeroing
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] dv_fix(input logic [DIV2_W-1:0] q,
                                                  input logic pos, input logic rz);
        logic signed [31:0] s;
        if (rz) s = '0;
        else if (pos) s = (q > DIV2_W'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-q);
        else s = (q > DIV2_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
        return s;
    endfunction

    logic               hit_reg;
    logic [30:0]        hd_reg;
    logic signed [31:0] px_reg, py_reg, dux_reg, duy_reg, dvx_reg, dvy_reg;
    logic [15:0]        u_reg;
    logic [16:0]        v_reg;
    logic               h;

    assign h = d3_side.hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (adv) m_valid_reg <= d3_vld;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg <= h;
            hd_reg  <= h ? d3_side.t : '0;
            px_reg  <= h ? d3_side.px : '0;
            py_reg  <= h ? d3_side.py : '0;
            u_reg   <= h ? d3_side.u : '0;
            v_reg   <= !h ? '0 : (disk_radius_reg == '0) ? 17'd65536 : q_v[16:0];
            dux_reg <= h ? d3_side.dux : '0;
            duy_reg <= h ? d3_side.duy : '0;
            dvx_reg <= h ? dv_fix(q_dx, d3_side.px_pos, d3_side.r_zero) : '0;
            dvy_reg <= h ? dv_fix(q_dy, d3_side.py_pos, d3_side.r_zero) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {dvy_reg, dvx_reg, duy_reg, dux_reg, v_reg, u_reg,
                       py_reg, px_reg, hd_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RDI_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_valid_reg && !hit_reg, m_tdata == '0)
    `RDI_ASSERT_IMPL(a_hit_range, aclk, aresetn, m_valid_reg && hit_reg, v_reg <= 17'd65536 && hd_reg != '0)
    `RDI_ASSERT_NEXT(a_cfg_radius, aclk, aresetn, cfg_valid && cfg_index == CFG_RADIUS, disk_radius_reg == $past(cfg_data[30:0]))

endmodule

// ===== sim/ray_disk_intersect_test.sv =====
// Self-checking testbench for the ray/disk intersection pipeline.
module ray_disk_intersect_test;
    import rdi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HOLD_CYCLES  = 600;   // long receiver hold-off
    localparam int  DRAIN_CYCLES = 300;   // longer than the pipeline latency
    localparam int  STALL_LIMIT  = 20000; // cycles with no transaction at all
    localparam int  RAYS_PER_SET = 320;
    localparam longint TWO_PI_FX = 64'd3373259426; // 2pi in Q3.29

    // arctangent of 2^-i in turns, 2^32 per circle
    localparam logic [31:0] ATAN_STEP [16] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz;
        logic [30:0]        len;
    } ray_t;

    typedef struct {
        logic               hit;
        logic [30:0]        t;
        logic signed [31:0] px, py;
        logic [15:0]        u;
        logic [16:0]        v;
        logic signed [31:0] dux, duy, dvx, dvy;
    } disk_hit_t;

    typedef struct {
        ray_t      ray;
        bit        typed;   // want holds a hand-written result
        disk_hit_t want;
    } plan_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [223:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    ray_disk_intersect dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // testbench copy of the disk registers
    logic [30:0]        radius_q = 31'd65536;
    logic signed [31:0] height_q = '0;

    disk_hit_t hits_due[$];     // expected results, oldest first
    int        fails      = 0;
    int        src_idle   = 0;  // percent of cycles the sender idles
    int        sink_idle  = 0;  // percent of cycles the receiver stalls
    int        hold_reqs  = 0;
    int        hold_seen  = 0;
    int        hold_left  = 0;
    int        quiet      = 0;

    // ---------------- predictor ----------------

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root, bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // vectoring CORDIC, angle in turns
    function automatic logic [31:0] turn_angle(longint x, longint y);
        logic [31:0] ang;
        longint      sx, sy;
        ang = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x   = -x;
            y   = -y;
            ang = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            sx = y >>> i;
            sy = x >>> i;
            if (y >= 0) begin
                x   = x + sx;
                y   = y - sy;
                ang = ang + ATAN_STEP[i];
            end else begin
                x   = x - sx;
                y   = y + sy;
                ang = ang - ATAN_STEP[i];
            end
        end
        return ang;
    endfunction

    function automatic disk_hit_t trace_ray(ray_t r);
        disk_hit_t   res;
        longint      rad, num, t, offx, offy, px, py, rt, vq;
        logic [63:0] d2;
        logic [31:0] ang, uq;
        res = '{default: '0};
        rad = longint'({33'b0, radius_q});
        if (r.dz == 0) return res;                       // parallel ray
        num = longint'(height_q) - longint'(r.oz);
        t   = (num * 65536) / longint'(r.dz);
        if (t <= 0) return res;
        if (r.len != LEN_UNBOUNDED && t >= longint'({33'b0, r.len})) return res;
        offx = (longint'(r.dx) * num) / longint'(r.dz);
        offy = (longint'(r.dy) * num) / longint'(r.dz);
        if (offx > 64'sd4294967296 || offx < -64'sd4294967296) return res;
        if (offy > 64'sd4294967296 || offy < -64'sd4294967296) return res;
        px = longint'(r.ox) + offx;
        py = longint'(r.oy) + offy;
        if (px != clamp32(px) || py != clamp32(py)) return res;   // far point
        d2 = 64'(px * px) + 64'(py * py);
        if (d2 > 64'(rad * rad)) return res;                       // outside disk
        rt  = longint'(int_sqrt(d2));
        ang = turn_angle(px, py);
        uq  = ((ang >> 15) + 32'd1) >> 1;
        vq  = (rad == 0) ? 65536 : ((rad - rt) * 65536) / rad;
        res.hit = 1'b1;
        res.t   = (t > 64'sd2147483647) ? 31'h7FFF_FFFF : 31'(t);
        res.px  = 32'(px);
        res.py  = 32'(py);
        res.u   = uq[15:0];
        res.v   = 17'(vq);
        res.dux = 32'(clamp32((-(py * TWO_PI_FX)) >>> 29));
        res.duy = 32'(clamp32((px * TWO_PI_FX) >>> 29));
        if (rt != 0) begin
            res.dvx = 32'(clamp32((-rad * px) / rt));
            res.dvy = 32'(clamp32((-rad * py) / rt));
        end
        return res;
    endfunction

    // ---------------- stimulus ----------------

    function automatic logic signed [31:0] rand_signed(int unsigned mag);
        longint v;
        v = longint'($urandom_range(mag));
        return ($urandom_range(1) != 0) ? 32'(-v) : 32'(v);
    endfunction

    // ray aimed at a point of the disk plane, mostly inside the radius
    function automatic ray_t aimed_ray();
        ray_t   r;
        longint num, span, tx, ty;
        r.dz = rand_signed(1 << 18);
        if (r.dz == 0) r.dz = 32'sd1;
        num = longint'($urandom_range(1 << 22)) + 1;
        if ((r.dz < 0) != ($urandom_range(9) == 0)) num = -num;
        r.oz = 32'(longint'(height_q) - num);
        r.dx = rand_signed(1 << 18);
        r.dy = rand_signed(1 << 18);
        span = longint'({33'b0, radius_q}) + longint'({33'b0, radius_q}) / 8;
        if (radius_q == 0 || $urandom_range(15) == 0) begin
            tx = 0;
            ty = 0;
        end else begin
            tx = longint'($urandom_range(32'(2 * span))) - span;
            ty = longint'($urandom_range(32'(2 * span))) - span;
        end
        r.ox = 32'(tx - (longint'(r.dx) * num) / longint'(r.dz));
        r.oy = 32'(ty - (longint'(r.dy) * num) / longint'(r.dz));
        case ($urandom_range(3))
            0, 1:    r.len = LEN_UNBOUNDED;
            2:       r.len = 31'($urandom);
            default: r.len = 31'($urandom_range(1 << 24));
        endcase
        return r;
    endfunction

    function automatic ray_t noise_ray();
        ray_t r;
        r.ox  = $urandom;
        r.oy  = $urandom;
        r.oz  = $urandom;
        r.dx  = $urandom;
        r.dy  = $urandom;
        r.dz  = ($urandom_range(7) == 0) ? 32'sd0 : 32'($urandom);
        r.len = 31'($urandom);
        return r;
    endfunction

    // one ray transaction; called at a rising edge
    task automatic send_ray(ray_t r, bit typed, disk_hit_t want);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, r.len, r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
        do @(posedge aclk); while (!s_tready);
        hits_due.push_back(typed ? want : trace_ray(r));
    endtask

    // one register write; valid drops for a cycle before returning
    task automatic write_reg(cfg_index_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_RADIUS) radius_q = val[30:0];
        else height_q = val;
        @(posedge aclk);
    endtask

    // pause the sender until the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (hits_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ---------------- receiver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    // ---------------- result check and watchdog ----------------

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            fails++;
        end
    endfunction

    always @(posedge aclk) begin
        disk_hit_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet = quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (hits_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual tdata %h",
                             $realtime, m_tdata);
                    fails++;
                end else begin
                    want = hits_due.pop_front();
                    check_field("hit",          want.hit, m_tuser[0]);
                    check_field("hit_distance", want.t,   m_tdata[30:0]);
                    check_field("point_x",      want.px,  $signed(m_tdata[62:31]));
                    check_field("point_y",      want.py,  $signed(m_tdata[94:63]));
                    check_field("coord_u",      want.u,   m_tdata[110:95]);
                    check_field("coord_v",      want.v,   m_tdata[127:111]);
                    check_field("dpdu_x",       want.dux, $signed(m_tdata[159:128]));
                    check_field("dpdu_y",       want.duy, $signed(m_tdata[191:160]));
                    check_field("dpdv_x",       want.dvx, $signed(m_tdata[223:192]));
                    check_field("dpdv_y",       want.dvy, $signed(m_tdata[255:224]));
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        plan_row_t   plan[$];
        plan_row_t   row;
        disk_hit_t   miss, centre;
        logic [30:0] radii [5];
        logic [31:0] heights [5];
        int          sent;

        miss   = '{default: '0};
        centre = '{default: '0};
        centre.hit = 1'b1;
        centre.t   = 31'd65536;
        centre.v   = 17'd65536;

        // directed rays, run with the reset radius 1.0 and height 0
        row = '{ray: '{default: '0}, typed: 1'b1, want: miss};
        row.ray.oz = -32'sd65536; row.ray.len = LEN_UNBOUNDED;
        plan.push_back(row);                                   // parallel ray
        row.ray.dz = 32'sd65536;
        row.want = centre; plan.push_back(row);                // centre hit
        row.ray.len = 31'd65536;
        row.want = miss; plan.push_back(row);                  // t equals length
        row.ray.len = 31'd65537;
        row.want = centre; plan.push_back(row);                // just inside length
        row.ray.dz = -32'sd65536; row.ray.len = LEN_UNBOUNDED;
        row.want = miss; plan.push_back(row);                  // hit behind origin
        row.ray.oz = 32'sd0; row.ray.dz = 32'sd1;
        plan.push_back(row);                                   // origin on plane
        row.typed = 1'b0;
        row.ray = '{ox: 0, oy: 0, oz: 32'h8000_0000, dx: 0, dy: 0, dz: 1,
                    len: LEN_UNBOUNDED};
        plan.push_back(row);                                   // saturated distance
        row.ray = '{ox: 32'sd30000, oy: -32'sd40000, oz: -32'sd65536,
                    dx: 0, dy: 0, dz: 32'sd65536, len: LEN_UNBOUNDED};
        plan.push_back(row);
        row.ray.ox = -32'sd46341; row.ray.oy = 32'sd46340; plan.push_back(row);
        row.ray.ox = 32'sd65536; row.ray.oy = 0; plan.push_back(row);  // rim
        row.ray.ox = 32'sd65537; plan.push_back(row);                  // outside disk
        row.ray.ox = -32'sd65536; plan.push_back(row);                 // half turn
        row.ray.ox = 0; row.ray.oy = -32'sd1; plan.push_back(row);
        row.ray = '{ox: 32'h7FFF_FFFF, oy: 32'h7FFF_FFFF, oz: 32'h7FFF_FFFF,
                    dx: 32'h7FFF_FFFF, dy: 32'h7FFF_FFFF, dz: 32'h7FFF_FFFF,
                    len: 31'h7FFF_FFFE};
        plan.push_back(row);
        row.ray = '{ox: 32'h8000_0000, oy: 32'h8000_0000, oz: 32'h8000_0000,
                    dx: 32'h8000_0000, dy: 32'h8000_0000, dz: 32'h8000_0000,
                    len: 31'h0};
        plan.push_back(row);
        row.ray = '{ox: 0, oy: 0, oz: 32'h8000_0000, dx: 32'h7FFF_FFFF,
                    dy: 32'h8000_0000, dz: 32'h7FFF_FFFF, len: LEN_UNBOUNDED};
        plan.push_back(row);                                   // far point
        row.ray = '{ox: 32'sd10, oy: 32'sd20, oz: -32'sd3, dx: -32'sd7,
                    dy: 32'sd5, dz: 32'sd1, len: LEN_UNBOUNDED};
        plan.push_back(row);

        // register settings, extremes first
        radii   = '{31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1 << 20, 31'd70000};
        heights = '{32'sd65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd0, -32'sd12345678};

        src_idle  = 14;
        sink_idle = 59;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) send_ray(plan[i].ray, plan[i].typed, plan[i].want);

        sent = 0;
        for (int set = 0; set < 5; set++) begin
            drain();
            write_reg(CFG_RADIUS, {1'b0, radii[set]});
            write_reg(CFG_HEIGHT, heights[set]);
            @(posedge aclk);
            if (set == 4) begin
                write_reg(CFG_RADIUS, {1'b0, 31'($urandom_range(1 << 22))});
                write_reg(CFG_HEIGHT, rand_signed(1 << 24));
                @(posedge aclk);
            end
            for (int n = 0; n < RAYS_PER_SET; n++) begin
                // idle profile: sender light / receiver heavy, then swapped, then none
                if (sent < 533) begin
                    src_idle = 14; sink_idle = 59;
                end else if (sent < 1066) begin
                    src_idle = 59; sink_idle = 14;
                end else begin
                    src_idle = 0; sink_idle = 0;
                end
                // receiver holds off while rays keep coming, fills the pipe
                if (n == 40 && (set == 1 || set == 4)) hold_reqs++;
                send_ray(($urandom_range(4) == 0) ? noise_ray() : aimed_ray(), 1'b0, miss);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (hits_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
